### rtl/mono_framebuffer_draw_engine_core_defines.svh
// assertion helpers
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define MFB_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("violated");
`define MFB_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("violated");
`endif

### rtl/mfb_pkg.sv
`default_nettype none
package mfb_pkg;
	localparam int WIDTH_DEF  = 128;
	localparam int HEIGHT_DEF = 64;
	localparam logic [2:0] OP_POINT  = 3'd0;
	localparam logic [2:0] OP_FILL   = 3'd1;
	localparam logic [2:0] OP_LINE   = 3'd2;
	localparam logic [2:0] OP_CIRCLE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DIV, ST_GEN, ST_CIRC, ST_RD, ST_WAIT, ST_OUT
	} state_t;

	// one pixel plot request to the memory unit
	typedef struct packed {
		logic       vld;
		logic [7:0] x;
		logic [7:0] y;
		logic       on;
	} plot_t;
endpackage
`default_nettype wire

### rtl/mfb_store.sv
`default_nettype none
// frame memory with a two-stage read-modify-write pipe and forwarding
module mfb_store
	import mfb_pkg::*;
#(
	parameter int WIDTH  = WIDTH_DEF,
	parameter int HEIGHT = HEIGHT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire plot_t      plot,
	input  wire logic       clr_en,
	input  wire logic [9:0] clr_addr,
	input  wire logic       rd_en,
	input  wire logic [9:0] rd_addr,
	output logic [7:0]      rd_data,
	output logic            busy
);
	localparam int PAGES = (HEIGHT + 7) / 8;
	logic [7:0] mem [1024];
	logic       vld_s1;
	logic [9:0] addr_s1;
	logic [7:0] bit_s1;
	logic       on_s1;
	logic [7:0] q_s1;
	logic       wv_q;
	logic [9:0] wa_q;
	logic [7:0] wd_q;
	logic       wv2_q;
	logic [9:0] wa2_q;
	logic [7:0] wd2_q;
	logic       in_rng;
	logic [9:0] addr;
	logic [2:0] pg;
	logic [7:0] cur;
	logic [7:0] nv;

	assign in_rng = (plot.x < 8'(WIDTH)) && (plot.y < 8'(HEIGHT));
	assign pg   = 3'(PAGES - 1) - plot.y[5:3];
	assign addr = {plot.x[6:0], pg};

	always_ff @(posedge clk) begin
		if (plot.vld && in_rng) q_s1 <= mem[addr];
		else if (rd_en) q_s1 <= mem[rd_addr];
		if (wv_q) mem[wa_q] <= wd_q;
		else if (clr_en) mem[clr_addr] <= 8'h00;
		addr_s1 <= (plot.vld && in_rng) ? addr : rd_addr;
		bit_s1  <= 8'h80 >> plot.y[2:0];
		on_s1   <= plot.on;
		wa_q    <= addr_s1;
		wd_q    <= nv;
		wa2_q   <= wa_q;
		wd2_q   <= wd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wv_q   <= 1'b0;
			wv2_q  <= 1'b0;
		end else begin
			vld_s1 <= plot.vld && in_rng;
			wv_q   <= vld_s1;
			wv2_q  <= wv_q;
		end
	end

	// newest pending write wins; the older one landed on the same edge as the read
	assign cur = (wv_q && wa_q == addr_s1) ? wd_q :
		((wv2_q && wa2_q == addr_s1) ? wd2_q : q_s1);
	assign nv  = on_s1 ? (cur | bit_s1) : (cur & ~bit_s1);
	assign rd_data = cur;
	assign busy = vld_s1 || wv_q;

	`include "mono_framebuffer_draw_engine_core_defines.svh"
	`MFB_ASSERT_NXT(a_wr_follows, vld_s1, wv_q)
	`MFB_ASSERT_IMP(a_no_clr_plot, clr_en, !plot.vld)
	`MFB_ASSERT_IMP(a_no_rd_plot, rd_en, !plot.vld)
endmodule
`default_nettype wire

### rtl/mono_framebuffer_draw_engine_core.sv
`default_nettype none
// One item at a time: s_tready is high only when idle; draws issue one pixel RMW a cycle.
// Point, fill and line draws plot from ST_GEN, then wait in ST_WAIT for the store to drain.
// A sloped line first runs the slope divide in ST_DIV; a circle plots its points in groups of eight.
// Read: result offered on m_tdata in ST_OUT; clear all reruns the clearing pass; zero radius, unused op: back to idle.
// Reset: a clearing pass over all 1024 bytes runs before the first beat is accepted.
module mono_framebuffer_draw_engine_core
	import mfb_pkg::*;
#(
	parameter int WIDTH  = WIDTH_DEF,
	parameter int HEIGHT = HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// op[2:0] x_a[9:3] y_a[15:10] x_b[22:16] y_b[28:23] radius[34:29] color[35]
	// page[38:36]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[7:0]
	output logic [7:0]       m_tdata
);
	localparam int PAGES = (HEIGHT + 7) / 8;
	state_t st_q, st_n;
	logic [2:0]  op_q;
	logic [7:0]  xa_q, ya_q, xb_q, yb_q, i_q, x_q, y_q;
	logic [6:0]  rd_x_q;
	logic [2:0]  pg_q;
	logic        col_q;
	logic [10:0] cnt_q;
	logic [11:0] num_q;   // dividend in, quotient out
	logic [7:0]  rem_q;
	logic [4:0]  kq_q;    // k/10
	logic [3:0]  kr_q;    // k%10
	logic [3:0]  mod_q;   // (i*k)%10 tracked as i grows
	logic [7:0]  div_q;   // (i*k)/10 mod 256
	logic signed [8:0] ca_q, cb_q, r_q;
	logic [2:0]  oct_q;
	logic [7:0]  out_q;
	plot_t       plot;
	logic        busy;
	logic [7:0]  rdat;
	logic        clr_en, rd_en;
	logic [9:0]  rd_addr;
	logic [7:0]  span;
	logic        acc;
	logic signed [8:0]  ca_n;
	logic signed [19:0] an2, cb2, r2;
	logic signed [8:0]  cx, cy, px, py;
	logic        div_done;
	logic [8:0]  dv_t;
	logic        dv_ge;
	logic [15:0] kmul;
	logic [7:0]  krem;
	logic [4:0]  msum;
	logic [7:0]  in_dy;
	logic        gen_last, gen_none, circ_stop;
	logic [2:0]  in_op;

	assign in_op = s_tdata[2:0];
	assign acc = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = (st_q == ST_OUT);
	assign m_tdata = out_q;
	assign span = xb_q - xa_q;
	assign in_dy = {2'b0, s_tdata[28:23]} - {2'b0, s_tdata[15:10]};

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_INIT: if (cnt_q == 11'd1023) st_n = ST_IDLE;
			ST_IDLE: if (acc) begin
				priority case (in_op)
					OP_POINT, OP_FILL: st_n = ST_GEN;
					OP_LINE: st_n = (s_tdata[9:3] != s_tdata[22:16] &&
						s_tdata[15:10] != s_tdata[28:23]) ? ST_DIV : ST_GEN;
					OP_CIRCLE: st_n = (s_tdata[34:29] == 6'd0) ? ST_IDLE : ST_CIRC;
					OP_CLEAR: st_n = ST_INIT;
					OP_READ: st_n = ST_RD;
					default: st_n = ST_IDLE;
				endcase
			end
			ST_DIV: if (div_done) st_n = ST_GEN;
			ST_GEN: if (gen_last) st_n = ST_WAIT;
			ST_CIRC: if (circ_stop) st_n = ST_WAIT;
			ST_RD: st_n = ST_WAIT;
			ST_WAIT: if (!busy) st_n = (op_q == OP_READ) ? ST_OUT : ST_IDLE;
			ST_OUT: if (m_tready) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	// generator step decisions
	always_comb begin
		gen_none = 1'b0;
		gen_last = 1'b0;
		unique case (op_q)
			OP_POINT: gen_last = 1'b1;
			OP_FILL: begin
				gen_none = (xa_q > xb_q) || (ya_q > yb_q);
				gen_last = gen_none || (x_q == xb_q && y_q == yb_q);
			end
			default: begin
				// line: vertical uses y span, else x span
				if (xa_q == xb_q) begin
					gen_none = !(yb_q > ya_q);
					gen_last = gen_none || (i_q + 8'd1 >= yb_q - ya_q);
				end else begin
					gen_none = !(xb_q > xa_q);
					gen_last = gen_none || (i_q + 8'd1 >= span);
				end
			end
		endcase
	end

	assign ca_n = ca_q + 9'sd1;
	assign an2 = 20'(ca_n) * 20'(ca_n);
	assign cb2 = 20'(cb_q) * 20'(cb_q);
	assign r2  = 20'(r_q) * 20'(r_q);
	// loop test 2*b*b >= r*r, checked before each group of eight points
	assign circ_stop = (oct_q == 3'd0) && ((cb2 + cb2) < r2);

	assign cx = $signed({1'b0, xa_q});
	assign cy = $signed({1'b0, ya_q});

	always_comb begin
		px = 9'sd0;
		py = 9'sd0;
		unique case (oct_q)
			3'd0: begin px = cx + ca_q; py = cy - cb_q; end
			3'd1: begin px = cx - ca_q; py = cy - cb_q; end
			3'd2: begin px = cx - ca_q; py = cy + cb_q; end
			3'd3: begin px = cx + ca_q; py = cy + cb_q; end
			3'd4: begin px = cx + cb_q; py = cy + ca_q; end
			3'd5: begin px = cx + cb_q; py = cy - ca_q; end
			3'd6: begin px = cx - cb_q; py = cy - ca_q; end
			default: begin px = cx - cb_q; py = cy + ca_q; end
		endcase
	end

	always_comb begin
		plot = '0;
		unique case (st_q)
			ST_GEN: begin
				plot.vld = !gen_none;
				plot.on = (op_q == OP_LINE) ? 1'b1 : col_q;
				if (op_q == OP_LINE) begin
					plot.x = (xa_q == xb_q) ? xa_q : xa_q + i_q;
					plot.y = (xa_q == xb_q) ? ya_q + i_q :
						((ya_q == yb_q) ? ya_q : ya_q + div_q);
				end else begin
					plot.x = x_q;
					plot.y = y_q;
				end
			end
			ST_CIRC: begin
				plot.vld = !circ_stop;
				plot.on = 1'b1;
				plot.x = px[7:0];
				plot.y = py[7:0];
			end
			default: plot = '0;
		endcase
	end

	assign clr_en = (st_q == ST_INIT);
	assign rd_en = (st_q == ST_RD);
	assign rd_addr = {rd_x_q, pg_q};
	assign div_done = (cnt_q == 11'd0);
	// restoring divide step of dy*10 by dx
	assign dv_t = {rem_q, num_q[11]};
	assign dv_ge = dv_t >= {1'b0, span};
	// k/10 as k*205 >> 11, exact for k below 1029
	assign kmul = 16'(num_q[7:0]) * 16'd205;
	assign krem = num_q[7:0] - 8'(kmul[15:11]) * 8'd10;
	assign msum = {1'b0, mod_q} + {1'b0, kr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_INIT;
		else st_q <= st_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (st_q == ST_IDLE && acc) cnt_q <= (in_op == OP_LINE) ? 11'd12 : '0;
		else if (st_q == ST_INIT) cnt_q <= (cnt_q == 11'd1023) ? '0 : cnt_q + 11'd1;
		else if (st_q == ST_DIV && cnt_q != 11'd0) cnt_q <= cnt_q - 11'd1;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q <= in_op;
			xa_q <= {1'b0, s_tdata[9:3]};
			ya_q <= {2'b0, s_tdata[15:10]};
			xb_q <= {1'b0, s_tdata[22:16]};
			yb_q <= {2'b0, s_tdata[28:23]};
			r_q  <= {3'b0, s_tdata[34:29]};
			ca_q <= '0;
			cb_q <= {3'b0, s_tdata[34:29]};
			oct_q <= '0;
			col_q <= s_tdata[35];
			pg_q <= s_tdata[38:36];
			rd_x_q <= s_tdata[9:3];
			x_q <= {1'b0, s_tdata[9:3]};
			y_q <= {2'b0, s_tdata[15:10]};
			i_q <= '0;
			mod_q <= '0;
			div_q <= '0;
			kq_q <= '0;
			kr_q <= '0;
			rem_q <= '0;
			num_q <= {4'b0, in_dy} * 12'd10;
		end
		if (st_q == ST_DIV && cnt_q != 11'd0) begin
			if (dv_ge) begin
				rem_q <= 8'(dv_t - {1'b0, span});
				num_q <= {num_q[10:0], 1'b1};
			end else begin
				rem_q <= dv_t[7:0];
				num_q <= {num_q[10:0], 1'b0};
			end
		end
		if (st_q == ST_DIV && div_done) begin
			kq_q <= kmul[15:11];
			kr_q <= krem[3:0];
		end
		if (st_q == ST_GEN) begin
			i_q <= i_q + 8'd1;
			if (y_q == yb_q) begin
				y_q <= ya_q;
				x_q <= x_q + 8'd1;
			end else y_q <= y_q + 8'd1;
			// running (i*k)/10
			if (msum >= 5'd10) begin
				mod_q <= 4'(msum - 5'd10);
				div_q <= div_q + {3'b0, kq_q} + 8'd1;
			end else begin
				mod_q <= msum[3:0];
				div_q <= div_q + {3'b0, kq_q};
			end
		end
		if (st_q == ST_CIRC) begin
			oct_q <= oct_q + 3'd1;
			if (oct_q == 3'd7) begin
				if (an2 + cb2 > r2) cb_q <= cb_q - 9'sd1;
				else ca_q <= ca_n;
			end
		end
		if (st_q == ST_WAIT && !busy) out_q <= (op_q == OP_READ &&
			{1'b0, rd_x_q} < 8'(WIDTH) && {1'b0, pg_q} < 4'(PAGES)) ? rdat : 8'h00;
	end

	mfb_store #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_store (
		.clk(clk), .arst_n(arst_n), .plot(plot), .clr_en(clr_en), .clr_addr(cnt_q[9:0]),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rdat), .busy(busy)
	);

	`include "mono_framebuffer_draw_engine_core_defines.svh"
	`MFB_ASSERT_IMP(a_out_idle, m_tvalid, !s_tready)
	`MFB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MFB_ASSERT_IMP(a_clr_no_plot, clr_en, !plot.vld)
endmodule
`default_nettype wire
